// ===== design/rrbm_pkg.sv =====
// Shared constants and codes for the ROM/RAM bank mapper with clock select.
package rrbm_pkg;

  localparam int unsigned RAM_BANKS_DEFAULT = 4;
  localparam int unsigned RAM_BANK_BYTES    = 8192;
  localparam logic [7:0]  ROM_BANKS_MAX     = 8'd128;

  localparam logic [7:0]  ROM_BANKS_RESET   = 8'd128;
  localparam logic [2:0]  RAM_BANKS_RESET   = 3'd4;

  localparam logic [0:0]  CMD_READ  = 1'b0;
  localparam logic [0:0]  CMD_WRITE = 1'b1;

  localparam logic [2:0]  KIND_DATA   = 3'd0;
  localparam logic [2:0]  KIND_ROM    = 3'd1;
  localparam logic [2:0]  KIND_CLK_RD = 3'd2;
  localparam logic [2:0]  KIND_CLK_WR = 3'd3;
  localparam logic [2:0]  KIND_LATCH  = 3'd4;
  localparam logic [2:0]  KIND_WRITE  = 3'd5;

  localparam logic [0:0]  REG_ROM_BANKS = 1'b0;
  localparam logic [0:0]  REG_RAM_BANKS = 1'b1;

  localparam logic [7:0]  OPEN_BUS     = 8'hFF;
  localparam logic [3:0]  RAM_EN_KEY   = 4'hA;
  localparam logic [7:0]  CLK_SEL_LO   = 8'h08;
  localparam logic [7:0]  CLK_SEL_HI   = 8'h0C;

endpackage

// ===== design/rrbm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rrbm_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rom_ram_bank_mapper_with_clock_select_unit.sv =====
// Top level of the ROM/RAM bank mapper with clock select.
//
//  channel  direction  handshake                    payload
//  apb      in/out     psel penable pwrite pready   paddr pwdata prdata
//  req      in         req_valid req_ready          cmd address data
//  rsp      out        rsp_valid rsp_ready          kind read_data rom_address clock_register
//
// One beat per cycle sustained while rsp_ready holds; each access passes
// through the decode plus RAM read stage, then the output register.
// The registered cartridge RAM read sets the stage between decode and output.
// Reset returns mapper registers to their defaults and clears handshake state; RAM contents stay undefined.
// A stalled rsp holds the output register and the RAM stage; req_ready drops
// only when both are full.
module rom_ram_bank_mapper_with_clock_select_unit #(
  parameter int unsigned RAM_BANKS_MAX = rrbm_pkg::RAM_BANKS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [0:0]  cmd,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [2:0]  kind,
  output logic [7:0]  read_data,
  output logic [20:0] rom_address,
  output logic [2:0]  clock_register
);
  import rrbm_pkg::*;

  localparam int unsigned RamDepth = RAM_BANKS_MAX * RAM_BANK_BYTES;
  localparam int unsigned RamAw    = $clog2(RamDepth);

  // configuration
  logic [7:0] rom_bank_count;
  logic [2:0] ram_bank_count;

  // mapper registers
  logic       ram_enable;
  logic [6:0] rom_bank;
  logic [1:0] ram_bank;
  logic       clock_mode;
  logic [2:0] clock_select;

  // RAM stage
  logic       s1_valid;
  logic [2:0] s1_kind;
  logic [7:0] s1_rd;
  logic [20:0] s1_rom;
  logic [2:0] s1_creg;
  logic       s1_use_ram;

  logic       accept;
  logic       s1_adv;
  logic       cfg_wr;

  logic [7:0] rom_n;
  logic [6:0] rom_mask;
  logic [2:0] ram_n;
  logic [1:0] ram_mask;
  logic [6:0] rom_bank_wr;

  logic       ram_area;
  logic       ram_path;
  logic       bank_ok;
  logic [14:0] ram_idx;

  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;

  logic [2:0] d_kind;
  logic [7:0] d_rd;
  logic [20:0] d_rom;
  logic [2:0] d_creg;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign s1_adv    = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_adv;
  assign accept    = req_valid && req_ready;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ROM_BANKS: prdata = {24'd0, rom_bank_count};
      REG_RAM_BANKS: prdata = {29'd0, ram_bank_count};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count <= ROM_BANKS_RESET;
      ram_bank_count <= RAM_BANKS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROM_BANKS: rom_bank_count <= pwdata[7:0];
        REG_RAM_BANKS: ram_bank_count <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // bank masks from clamped counts, and the ROM bank write value with bank 0 mapped to 1
  always_comb begin
    rom_n    = (rom_bank_count > ROM_BANKS_MAX) ? ROM_BANKS_MAX : rom_bank_count;
    rom_mask = 7'(rom_n - 8'd1);
    ram_n    = (32'(ram_bank_count) > RAM_BANKS_MAX) ? 3'(RAM_BANKS_MAX) : ram_bank_count;
    ram_mask = (ram_n == 3'd0) ? 2'd0 : 2'(ram_n - 3'd1);
    rom_bank_wr = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
  end

  assign ram_area = (address[15:13] == 3'b101);
  assign ram_path = ram_area && ram_enable && !clock_mode && (ram_bank_count != 3'd0);
  assign bank_ok  = 32'(ram_bank) < RAM_BANKS_MAX;
  assign ram_idx  = {ram_bank, address[12:0]};
  assign ram_we   = accept && (cmd == CMD_WRITE) && ram_path && bank_ok;
  assign ram_re   = accept && (cmd == CMD_READ) && ram_path && bank_ok;

  always_comb begin
    d_kind = KIND_DATA;
    d_rd   = 8'd0;
    d_rom  = 21'd0;
    d_creg = 3'd0;
    if (cmd == CMD_READ) begin
      if (address[15:14] == 2'b00) begin
        d_kind = KIND_ROM;
        d_rom  = {5'd0, address};
      end else if (address[15:14] == 2'b01) begin
        d_kind = KIND_ROM;
        d_rom  = {rom_bank, address[13:0]};
      end else if (ram_area && ram_enable && clock_mode) begin
        d_kind = KIND_CLK_RD;
        d_creg = clock_select;
      end else begin
        d_rd = OPEN_BUS;
      end
    end else begin
      d_kind = KIND_WRITE;
      if (address[15:13] == 3'b011) begin
        d_kind = KIND_LATCH;
        d_rd   = data;
      end else if (ram_area && ram_enable && clock_mode) begin
        d_kind = KIND_CLK_WR;
        d_rd   = data;
        d_creg = clock_select;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable   <= 1'b0;
      rom_bank     <= 7'd1;
      ram_bank     <= 2'd0;
      clock_mode   <= 1'b0;
      clock_select <= 3'd0;
    end else if (accept && (cmd == CMD_WRITE)) begin
      case (address[15:13])
        3'b000: ram_enable <= (data[3:0] == RAM_EN_KEY);
        3'b001: rom_bank   <= rom_bank_wr & rom_mask;
        3'b010: begin
          if (data >= CLK_SEL_LO && data <= CLK_SEL_HI) begin
            clock_mode   <= 1'b1;
            clock_select <= data[2:0];
          end else begin
            clock_mode <= 1'b0;
            ram_bank   <= data[1:0] & ram_mask;
          end
        end
        default: ;
      endcase
    end
  end

  rrbm_ram #(
    .WIDTH (8),
    .DEPTH (RamDepth)
  ) u_cart_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_idx[RamAw-1:0]),
    .wdata (data),
    .re    (ram_re),
    .raddr (ram_idx[RamAw-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind    <= d_kind;
      s1_rd      <= d_rd;
      s1_rom     <= d_rom;
      s1_creg    <= d_creg;
      s1_use_ram <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      kind           <= s1_kind;
      read_data      <= s1_use_ram ? ram_rdata : s1_rd;
      rom_address    <= s1_rom;
      clock_register <= s1_creg;
    end
  end

  a_ram_one_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("RAM read and write in the same cycle");

  a_ram_read_lands: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> s1_valid && s1_use_ram)
    else $error("RAM read without a waiting stage entry");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_kind) && $stable(s1_use_ram))
    else $error("RAM stage lost its beat under stall");

  a_rom_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (kind == KIND_ROM) |-> (read_data == 8'd0) && (clock_register == 3'd0))
    else $error("ROM fetch beat carries stray fields");

endmodule
